### rtl/core/dpbf_pkg.sv
package dpbf_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned QUERY_W = 31;
  localparam int unsigned DELTA_W = 27;
  localparam int unsigned CFG_IDX_W = 3;

  // The minimum trackers start from the largest positive coordinate.
  localparam logic [COORD_W-1:0] COORD_TOP = {1'b0, {(COORD_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ENABLE = 3'd0,
    CFG_QUERY_LEFT    = 3'd1,
    CFG_QUERY_TOP     = 3'd2,
    CFG_QUERY_RIGHT   = 3'd3,
    CFG_QUERY_BOTTOM  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               end_of_object;
    logic               keep;
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_bottom;
  } res_t;

endpackage

### rtl/core/delta_polyline_bbox_filter.sv
// Delta polyline decoder with bounding-box filter. Each accepted item is one
// vertex; its delta pair is shifted left by SHIFT and added (wrapping, 32 bit)
// to a running point, which a vertex marked first instead seeds from the tile
// origin with its low SHIFT bits cleared. Every item gives exactly one result
// item: the absolute point, and on the last vertex of an object the object's
// box and the keep flag (always 1 with the filter off). The block takes one
// item per clock while in_stall is low; each result is registered after the
// single stage of add, min/max and signed compares. A two-entry output buffer
// lets one more item in while a result is stalled.
module delta_polyline_bbox_filter
  import dpbf_pkg::*;
#(
  parameter int unsigned SHIFT = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [QUERY_W-1:0]         cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       first,
  input  logic                       last,
  input  logic [QUERY_W-1:0]         origin_x,
  input  logic [QUERY_W-1:0]         origin_y,
  input  logic signed [DELTA_W-1:0]  delta_x,
  input  logic signed [DELTA_W-1:0]  delta_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [COORD_W-1:0]  point_x,
  output logic signed [COORD_W-1:0]  point_y,
  output logic                       end_of_object,
  output logic                       keep,
  output logic signed [COORD_W-1:0]  box_left,
  output logic signed [COORD_W-1:0]  box_top,
  output logic signed [COORD_W-1:0]  box_right,
  output logic signed [COORD_W-1:0]  box_bottom
);

  localparam logic [QUERY_W-1:0] ORIGIN_MASK = ~((QUERY_W'(1) << SHIFT) - QUERY_W'(1));

  logic               filter_enable;
  logic [QUERY_W-1:0] query_left;
  logic [QUERY_W-1:0] query_top;
  logic [QUERY_W-1:0] query_right;
  logic [QUERY_W-1:0] query_bottom;

  logic [COORD_W-1:0] run_x;
  logic [COORD_W-1:0] run_y;
  logic [COORD_W-1:0] min_x;
  logic [COORD_W-1:0] min_y;
  logic [COORD_W-1:0] max_x;
  logic [COORD_W-1:0] max_y;
  logic               hit_seen;

  logic [COORD_W-1:0] run_x_next;
  logic [COORD_W-1:0] run_y_next;
  logic [COORD_W-1:0] min_x_next;
  logic [COORD_W-1:0] min_y_next;
  logic [COORD_W-1:0] max_x_next;
  logic [COORD_W-1:0] max_y_next;
  logic               hit_seen_next;

  logic [COORD_W-1:0] base_x;
  logic [COORD_W-1:0] base_y;
  logic [COORD_W-1:0] min_x_cur;
  logic [COORD_W-1:0] min_y_cur;
  logic [COORD_W-1:0] max_x_cur;
  logic [COORD_W-1:0] max_y_cur;
  logic signed [COORD_W-1:0] step_x;
  logic signed [COORD_W-1:0] step_y;
  logic signed [COORD_W-1:0] ql;
  logic signed [COORD_W-1:0] qt;
  logic signed [COORD_W-1:0] qr;
  logic signed [COORD_W-1:0] qb;
  logic               in_box;
  logic               overlap;
  res_t               res_new;

  res_t               out_res;
  res_t               skid_res;
  logic               skid_full;
  logic               in_acc;
  logic               out_acc;

  assign in_stall = skid_full;
  assign in_acc   = in_valid & ~in_stall;
  assign out_acc  = out_valid & ~out_stall;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      query_left    <= '0;
      query_top     <= '0;
      query_right   <= '1;
      query_bottom  <= '1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        CFG_QUERY_LEFT:    query_left    <= cfg_data;
        CFG_QUERY_TOP:     query_top     <= cfg_data;
        CFG_QUERY_RIGHT:   query_right   <= cfg_data;
        CFG_QUERY_BOTTOM:  query_bottom  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    step_x = COORD_W'(delta_x) <<< SHIFT;
    step_y = COORD_W'(delta_y) <<< SHIFT;

    base_x    = first ? {1'b0, origin_x & ORIGIN_MASK} : run_x;
    base_y    = first ? {1'b0, origin_y & ORIGIN_MASK} : run_y;
    min_x_cur = first ? COORD_TOP : min_x;
    min_y_cur = first ? COORD_TOP : min_y;
    max_x_cur = first ? '0 : max_x;
    max_y_cur = first ? '0 : max_y;

    run_x_next = base_x + step_x;
    run_y_next = base_y + step_y;

    ql = {1'b0, query_left};
    qt = {1'b0, query_top};
    qr = {1'b0, query_right};
    qb = {1'b0, query_bottom};

    in_box = ($signed(run_x_next) >= ql) && ($signed(run_x_next) <= qr) &&
             ($signed(run_y_next) >= qt) && ($signed(run_y_next) <= qb);
    hit_seen_next = (~first & hit_seen) | in_box;

    min_x_next = ($signed(run_x_next) < $signed(min_x_cur)) ? run_x_next : min_x_cur;
    min_y_next = ($signed(run_y_next) < $signed(min_y_cur)) ? run_y_next : min_y_cur;
    max_x_next = ($signed(run_x_next) > $signed(max_x_cur)) ? run_x_next : max_x_cur;
    max_y_next = ($signed(run_y_next) > $signed(max_y_cur)) ? run_y_next : max_y_cur;

    // Boxes that share only an edge still count as overlapping.
    overlap = !(($signed(min_x_next) > qr) || ($signed(max_x_next) < ql) ||
                ($signed(min_y_next) > qb) || ($signed(max_y_next) < qt));

    res_new.point_x       = run_x_next;
    res_new.point_y       = run_y_next;
    res_new.end_of_object = last;
    res_new.keep          = last & (~filter_enable | hit_seen_next | overlap);
    res_new.box_left      = last ? min_x_next : '0;
    res_new.box_top       = last ? min_y_next : '0;
    res_new.box_right     = last ? max_x_next : '0;
    res_new.box_bottom    = last ? max_y_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_x    <= '0;
      run_y    <= '0;
      min_x    <= COORD_TOP;
      min_y    <= COORD_TOP;
      max_x    <= '0;
      max_y    <= '0;
      hit_seen <= 1'b0;
    end else if (in_acc) begin
      run_x    <= run_x_next;
      run_y    <= run_y_next;
      min_x    <= min_x_next;
      min_y    <= min_y_next;
      max_x    <= max_x_next;
      max_y    <= max_y_next;
      hit_seen <= hit_seen_next;
    end
  end

  // Output register with a skid entry behind it. The skid entry fills only
  // when a new item arrives while the output register is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || out_acc) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_acc) begin
      if (skid_full) begin
        out_res <= skid_res;
      end else if (in_acc) begin
        out_res <= res_new;
      end
    end else if (in_acc) begin
      skid_res <= res_new;
    end
  end

  assign point_x       = out_res.point_x;
  assign point_y       = out_res.point_y;
  assign end_of_object = out_res.end_of_object;
  assign keep          = out_res.keep;
  assign box_left      = out_res.box_left;
  assign box_top       = out_res.box_top;
  assign box_right     = out_res.box_right;
  assign box_bottom    = out_res.box_bottom;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid entry holds an item while the output register is empty");

  a_mid_object_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !end_of_object) |->
      (!keep && box_left == '0 && box_top == '0 && box_right == '0 && box_bottom == '0))
    else $error("result inside an object carries keep or box data");

  a_filter_off_keeps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_object && !filter_enable) |-> keep)
    else $error("object dropped while the filter is off");

endmodule
